// File: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and fixed-point constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int unsigned HUE_W  = 12;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned H6_W   = HUE_W + 3;
    localparam int unsigned BIG_W  = 20;
    localparam int unsigned PROD_W = BIG_W + CHAN_W;
    localparam int unsigned Y_W    = 16;

    localparam logic [CHAN_W-1:0] FULL     = 8'd255;
    localparam logic [HUE_W:0]    FRAC_ONE = 13'd4096;
    localparam logic [BIG_W-1:0]  BIG      = 20'd1044480;
    localparam logic [PROD_W-1:0] HALF_BIG = 28'd522240;
    localparam logic [Y_W-1:0]    HALF_FULL = 16'd127;

    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts one HSV pixel word to one RGB pixel word in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_hue[11:0], s_saturation, s_brightness
//  m_      | out       | m_valid / m_ready  | m_red, m_green, m_blue
//
//  m_valid is the stage 4 valid bit; one word per cycle while m_ready is high.
//  Stages: hue*6 split, s*f products, v*level products, /255 and channel select.
//  aresetn (synchronous, active low) clears the stage valid bits only.
//  Each stage holds while its successor is full and stalled; bubbles collapse.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [HUE_W-1:0]  s_hue,
    input  logic [CHAN_W-1:0] s_saturation,
    input  logic [CHAN_W-1:0] s_brightness,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red,
    output logic [CHAN_W-1:0] m_green,
    output logic [CHAN_W-1:0] m_blue
);

    function automatic logic [CHAN_W-1:0] div255(input logic [Y_W-1:0] y);
        logic [Y_W:0] acc;
        acc = {1'b0, y} + {9'd0, y[Y_W-1:8]} + 17'd1;
        return acc[Y_W-1:8];
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: sector and fraction
    logic [H6_W-1:0]   h6;
    sector_t           sec1_reg;
    logic [HUE_W-1:0]  f1_reg;
    logic [HUE_W:0]    fc1_reg;
    logic [CHAN_W-1:0] s1_reg, bv1_reg;

    assign h6 = ({3'b000, s_hue} << 2) + ({3'b000, s_hue} << 1);

    always_ff @(posedge aclk) begin
        if (en1) begin
            sec1_reg <= sector_t'(h6[H6_W-1:HUE_W]);
            f1_reg   <= h6[HUE_W-1:0];
            fc1_reg  <= FRAC_ONE - {1'b0, h6[HUE_W-1:0]};
            s1_reg   <= s_saturation;
            bv1_reg  <= s_brightness;
        end
    end

    // stage 2: saturation products
    logic [BIG_W-1:0]   sf;
    logic [BIG_W:0]     sfc;
    logic [Y_W-1:0]     vp;
    sector_t            sec2_reg;
    logic               grey2_reg;
    logic [CHAN_W-1:0]  bv2_reg;
    logic [BIG_W-1:0]   lq2_reg, lt2_reg;
    logic [Y_W-1:0]     np2_reg;

    assign sf  = s1_reg * f1_reg;
    assign sfc = s1_reg * fc1_reg;
    assign vp  = bv1_reg * (FULL - s1_reg);

    always_ff @(posedge aclk) begin
        if (en2) begin
            sec2_reg  <= sec1_reg;
            grey2_reg <= (s1_reg == '0);
            bv2_reg   <= bv1_reg;
            lq2_reg   <= BIG - sf;
            lt2_reg   <= BIG - sfc[BIG_W-1:0];
            np2_reg   <= vp + HALF_FULL;
        end
    end

    // stage 3: value products, rounded and scaled by 1/4096
    logic [PROD_W-1:0] xq, xt;
    sector_t           sec3_reg;
    logic              grey3_reg;
    logic [CHAN_W-1:0] bv3_reg;
    logic [Y_W-1:0]    yq3_reg, yt3_reg, yp3_reg;

    assign xq = bv2_reg * lq2_reg + HALF_BIG;
    assign xt = bv2_reg * lt2_reg + HALF_BIG;

    always_ff @(posedge aclk) begin
        if (en3) begin
            sec3_reg  <= sec2_reg;
            grey3_reg <= grey2_reg;
            bv3_reg   <= bv2_reg;
            yq3_reg   <= xq[PROD_W-1:HUE_W];
            yt3_reg   <= xt[PROD_W-1:HUE_W];
            yp3_reg   <= np2_reg;
        end
    end

    // stage 4: divide by 255 and route by sector
    logic [CHAN_W-1:0] p, q, t;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;

    assign p = div255(yp3_reg);
    assign q = div255(yq3_reg);
    assign t = div255(yt3_reg);

    always_comb begin
        if (grey3_reg) begin
            red_next   = bv3_reg;
            green_next = bv3_reg;
            blue_next  = bv3_reg;
        end else begin
            case (sec3_reg)
                SECT_RED_YEL: begin
                    red_next = bv3_reg; green_next = t; blue_next = p;
                end
                SECT_YEL_GRN: begin
                    red_next = q; green_next = bv3_reg; blue_next = p;
                end
                SECT_GRN_CYN: begin
                    red_next = p; green_next = bv3_reg; blue_next = t;
                end
                SECT_CYN_BLU: begin
                    red_next = p; green_next = q; blue_next = bv3_reg;
                end
                SECT_BLU_MAG: begin
                    red_next = t; green_next = p; blue_next = bv3_reg;
                end
                default: begin
                    red_next = bv3_reg; green_next = p; blue_next = q;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule
